/* src/brd_pkg.sv */
// Shared types and codes for the bounded record deque.
// Used by brd_cell and bounded_record_deque; no dependencies.
package brd_pkg;

    // One record: low fields in the low bits so it maps straight onto tdata.
    typedef struct packed {
        logic [7:0]  name_high;
        logic [63:0] name_low;
        logic [7:0]  id_high;
        logic [63:0] id_low;
    } rec_t;

    localparam int unsigned REC_W = $bits(rec_t);

    typedef enum logic [2:0] {
        FN_DISPLAY   = 3'd0,
        FN_INS_FRONT = 3'd1,
        FN_INS_REAR  = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_REAR  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Per-cell load selection.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,     // take the incoming record
        CELL_SHIFT_R,  // take the left neighbor (toward rear)
        CELL_SHIFT_L,  // take the right neighbor (toward front)
        CELL_WRAP      // take cell 0 (display rotation)
    } cell_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_DISP
    } state_t;

endpackage

/* src/bounded_record_deque.sv */
// Bounded double-ended queue of records, built as a row of shifting cells.
// Insert/delete: result valid the cycle after accept.
// Display: one result per cycle while m_tready is high, count results (one
// empty-status result on an empty deque).
// One item in flight; next item accepted once its last result is taken.
// Reset (rst_n low, async): empty, idle. Record cells are not reset.
// Depends on brd_pkg and brd_cell.
module bounded_record_deque #(
    parameter int unsigned CAPACITY = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    // input transactions
    input  logic         s_tvalid,
    output logic         s_tready,
    // [63:0] id_low, [71:64] id_high, [135:72] name_low, [143:136] name_high
    input  logic [143:0] s_tdata,
    // [2:0] func
    input  logic [2:0]   s_tuser,
    // result transactions
    output logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] out_id_low, [71:64] out_id_high, [135:72] out_name_low,
    // [143:136] out_name_high, [147:144] occupancy, [151:148] zero
    output logic [151:0] m_tdata,
    // [1:0] status
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    // Outside a display, the front of the queue lives in cell 0; cell i holds the entry
    // i places behind the front. Count says how many cells are live.
    brd_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    brd_pkg::status_t status_reg, status_next;

    brd_pkg::rec_t     new_rec;
    brd_pkg::rec_t     cell_rec [CAPACITY];
    brd_pkg::cell_sel_t cell_sel [CAPACITY];

    brd_pkg::func_t   func;
    logic             in_acc;
    logic             out_acc;
    logic             is_full;
    logic             is_empty;
    logic             disp_last;
    logic [CNT_W+3:0] count_wide;

    assign new_rec  = brd_pkg::rec_t'(s_tdata);
    assign func     = brd_pkg::func_t'(s_tuser);
    assign in_acc   = s_tvalid & s_tready;
    assign out_acc  = m_tvalid & m_tready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign disp_last = (idx_reg + CNT_W'(1) == count_reg);
    assign count_wide = {4'b0000, count_reg};

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        brd_cell u_cell (
            .clk       (clk),
            .sel       (cell_sel[g]),
            .new_rec   (new_rec),
            .left_rec  ((g == 0) ? new_rec : cell_rec[(g == 0) ? 0 : g - 1]),
            .right_rec ((g == CAPACITY - 1) ? cell_rec[g]
                                            : cell_rec[(g == CAPACITY - 1) ? g : g + 1]),
            .wrap_rec  (cell_rec[0]),
            .rec       (cell_rec[g])
        );
    end

    // Datapath control: counters, status and per-cell moves
    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_sel[i] = brd_pkg::CELL_HOLD;
        end

        if (state_reg == brd_pkg::ST_IDLE && in_acc)
        begin
            idx_next    = '0;
            status_next = brd_pkg::STAT_OK;
            case (func)
                brd_pkg::FN_DISPLAY:
                begin
                    if (is_empty)
                    begin
                        status_next = brd_pkg::STAT_EMPTY;
                    end
                end
                brd_pkg::FN_INS_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = brd_pkg::STAT_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            cell_sel[i] = (i == 0) ? brd_pkg::CELL_LOAD
                                                   : brd_pkg::CELL_SHIFT_R;
                        end
                    end
                end
                brd_pkg::FN_INS_REAR:
                begin
                    if (is_full)
                    begin
                        status_next = brd_pkg::STAT_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            if (CNT_W'(i) == count_reg)
                            begin
                                cell_sel[i] = brd_pkg::CELL_LOAD;
                            end
                        end
                    end
                end
                brd_pkg::FN_DEL_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = brd_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        for (int i = 0; i < CAPACITY; i++)
                        begin
                            cell_sel[i] = brd_pkg::CELL_SHIFT_L;
                        end
                    end
                end
                brd_pkg::FN_DEL_REAR:
                begin
                    if (is_empty)
                    begin
                        status_next = brd_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
        else if (state_reg == brd_pkg::ST_DISP && out_acc)
        begin
            // rotate live cells toward the front; after count steps the
            // chain is back in its original order
            idx_next = idx_reg + CNT_W'(1);
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (CNT_W'(i) + CNT_W'(1) == count_reg)
                begin
                    cell_sel[i] = brd_pkg::CELL_WRAP;
                end
                else if (CNT_W'(i) + CNT_W'(1) < count_reg)
                begin
                    cell_sel[i] = brd_pkg::CELL_SHIFT_L;
                end
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brd_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (func)
                        brd_pkg::FN_DISPLAY:
                            state_next = is_empty ? brd_pkg::ST_RESP : brd_pkg::ST_DISP;
                        brd_pkg::FN_INS_FRONT,
                        brd_pkg::FN_INS_REAR,
                        brd_pkg::FN_DEL_FRONT,
                        brd_pkg::FN_DEL_REAR:
                            state_next = brd_pkg::ST_RESP;
                        default:
                            state_next = brd_pkg::ST_IDLE;
                    endcase
                end
            end
            brd_pkg::ST_RESP:
            begin
                if (out_acc)
                begin
                    state_next = brd_pkg::ST_IDLE;
                end
            end
            brd_pkg::ST_DISP:
            begin
                if (out_acc && disp_last)
                begin
                    state_next = brd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: display streams straight from cell 0
    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        m_tlast  = 1'b0;
        m_tuser  = status_reg;
        m_tdata  = '0;
        m_tdata[147:144] = count_wide[3:0];
        case (state_reg)
            brd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            brd_pkg::ST_RESP:
            begin
                m_tvalid = 1'b1;
                m_tlast  = 1'b1;
            end
            brd_pkg::ST_DISP:
            begin
                m_tvalid = 1'b1;
                m_tlast  = disp_last;
                m_tuser  = brd_pkg::STAT_OK;
                m_tdata[brd_pkg::REC_W-1:0] = cell_rec[0];
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= brd_pkg::ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            status_reg <= brd_pkg::STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
        end
    end

endmodule

/* src/brd_cell.sv */
// One slot of the deque chain: holds a record and loads from the input, a neighbor or cell 0.
// Depends on brd_pkg.
module brd_cell (
    input  logic               clk,
    input  brd_pkg::cell_sel_t sel,
    input  brd_pkg::rec_t      new_rec,
    input  brd_pkg::rec_t      left_rec,
    input  brd_pkg::rec_t      right_rec,
    input  brd_pkg::rec_t      wrap_rec,
    output brd_pkg::rec_t      rec
);

    brd_pkg::rec_t rec_reg;

    always_ff @(posedge clk)
    begin
        case (sel)
            brd_pkg::CELL_LOAD:    rec_reg <= new_rec;
            brd_pkg::CELL_SHIFT_R: rec_reg <= left_rec;
            brd_pkg::CELL_SHIFT_L: rec_reg <= right_rec;
            brd_pkg::CELL_WRAP:    rec_reg <= wrap_rec;
            default:               rec_reg <= rec_reg;
        endcase
    end

    assign rec = rec_reg;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for bounded_record_deque: directed and random
// transaction streams, a behavioral deque predictor and a result scoreboard.
// Depends on brd_pkg and the bounded_record_deque RTL.
module tb_top;

    localparam int unsigned DEPTH      = 8;
    localparam int unsigned RAND_OPS   = 350;
    localparam int unsigned MAX_REPORT = 10;
    localparam int unsigned HOLD_LEN   = 400;   // long receiver hold-off, in cycles

    // One command for the deque, as it travels on the slave side.
    typedef struct {
        logic [2:0]    fn;
        brd_pkg::rec_t rec;
    } deque_cmd_t;

    // One result transaction as the master side should present it.
    typedef struct {
        logic [1:0]    status;
        brd_pkg::rec_t rec;
        logic [3:0]    occ;
        logic          last;
    } reply_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    bounded_record_deque #(
        .CAPACITY (DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // id_low, id_high, name_low, name_high
        .s_tuser  (s_tuser),    // func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // out_id_low, out_id_high, out_name_low,
                                // out_name_high, occupancy, zero pad
        .m_tuser  (m_tuser),    // status
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stimulus and scoreboard storage
    deque_cmd_t deque_cmds[$];
    reply_t     expected_replies[$];

    // Predicted deque contents: ring of records, head slot and record count
    brd_pkg::rec_t ring[DEPTH];
    logic [2:0]    head_slot = '0;
    logic [3:0]    held = '0;

    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    bit          in_taken = 1'b0;   // set at the edge that accepts an input

    // Driver / monitor working variables
    deque_cmd_t  next_cmd;
    int unsigned tx_wait = 0;
    int unsigned tx_burst = 0;
    int unsigned rx_stall = 0;
    int unsigned rx_burst = 0;
    int unsigned hold_cycles = 0;
    bit          hold_done = 1'b0;
    reply_t      got;
    reply_t      want;

    // Idle length: mostly short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic brd_pkg::rec_t rand_rec();
        brd_pkg::rec_t r;
        int unsigned   roll;
        roll = $urandom_range(0, 11);
        r.id_low    = {$urandom, $urandom};
        r.id_high   = 8'($urandom_range(0, 255));
        r.name_low  = {$urandom, $urandom};
        r.name_high = 8'($urandom_range(0, 255));
        if (roll == 0)
            r = '0;
        else if (roll == 1)
            r = '1;
        else if (roll == 2)
        begin
            // strings of eight bytes or fewer: ninth byte absent
            r.id_high   = 8'h00;
            r.name_high = 8'h00;
        end
        return r;
    endfunction

    task automatic push_cmd(input logic [2:0] fn, input brd_pkg::rec_t rec);
        deque_cmd_t c;
        c.fn  = fn;
        c.rec = rec;
        deque_cmds.push_back(c);
    endtask

    task automatic push_reply(input logic [1:0] status, input brd_pkg::rec_t rec,
                              input logic last);
        reply_t r;
        r.status = status;
        r.rec    = rec;
        r.occ    = held;
        r.last   = last;
        expected_replies.push_back(r);
    endtask

    // Behavioral deque: updates the predicted ring and queues the expected
    // result transactions for one accepted command.
    task automatic apply_deque_cmd(input logic [2:0] fn, input brd_pkg::rec_t rec);
        int unsigned i;
        case (fn)
            brd_pkg::FN_DISPLAY:
            begin
                if (held == 0)
                    push_reply(brd_pkg::STAT_EMPTY, '0, 1'b1);
                else
                    for (i = 0; i < held; i++)
                        push_reply(brd_pkg::STAT_OK,
                                   ring[3'((head_slot + i) % DEPTH)],
                                   (i + 1 == held));
            end
            brd_pkg::FN_INS_FRONT, brd_pkg::FN_INS_REAR:
            begin
                if (held >= DEPTH)
                    push_reply(brd_pkg::STAT_FULL, '0, 1'b1);
                else
                begin
                    if (fn == brd_pkg::FN_INS_FRONT)
                    begin
                        head_slot = 3'((head_slot + DEPTH - 1) % DEPTH);
                        ring[head_slot] = rec;
                    end
                    else
                        ring[3'((head_slot + held) % DEPTH)] = rec;
                    held = held + 4'd1;
                    push_reply(brd_pkg::STAT_OK, '0, 1'b1);
                end
            end
            brd_pkg::FN_DEL_FRONT, brd_pkg::FN_DEL_REAR:
            begin
                if (held == 0)
                    push_reply(brd_pkg::STAT_EMPTY, '0, 1'b1);
                else
                begin
                    if (fn == brd_pkg::FN_DEL_FRONT)
                        head_slot = 3'((head_slot + 1) % DEPTH);
                    held = held - 4'd1;
                    push_reply(brd_pkg::STAT_OK, '0, 1'b1);
                end
            end
            default: ;  // unused func codes: no result, no change
        endcase
    endtask

    // Slave-side driver: changes on the falling edge. An offered item stays
    // up until taken; the gap before the next one is drawn per item, with
    // occasional bursts of back-to-back transactions.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !in_taken)
                ;   // still waiting for s_tready
            else if (tx_wait > 0)
            begin
                s_tvalid <= 1'b0;
                tx_wait--;
            end
            else if (deque_cmds.size() > 0)
            begin
                next_cmd = deque_cmds.pop_front();
                s_tuser  <= next_cmd.fn;
                s_tdata  <= next_cmd.rec;
                s_tvalid <= 1'b1;
                if (tx_burst > 0)
                begin
                    tx_burst--;
                    tx_wait = 0;
                end
                else if ($urandom_range(0, 39) == 0)
                begin
                    tx_burst = $urandom_range(15, 40);
                    tx_wait  = 0;
                end
                else
                    tx_wait = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // Master-side ready: random stalls, bursts of steady ready, and one long
    // hold-off once traffic is under way so the deque backs up its input.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (!hold_done && results_seen >= 60)
            begin
                hold_done   = 1'b1;
                hold_cycles = HOLD_LEN - 1;
                m_tready    <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                m_tready <= 1'b0;
                rx_stall--;
            end
            else if (rx_burst > 0)
            begin
                m_tready <= 1'b1;
                rx_burst--;
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                rx_burst = $urandom_range(15, 40);
                m_tready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 70)
                m_tready <= 1'b1;
            else
            begin
                rx_stall = pick_gap();
                m_tready <= 1'b0;
            end
        end
    end

    // Monitor: predicts on every accepted input transaction and checks every
    // accepted result transaction against the oldest expectation.
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            apply_deque_cmd(s_tuser, brd_pkg::rec_t'(s_tdata));
            in_taken = 1'b1;
        end
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            got.status = m_tuser;
            got.rec    = m_tdata[143:0];
            got.occ    = m_tdata[147:144];
            got.last   = m_tlast;
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("mismatch: unexpected result %0d, status %0d occ %0d last %0b",
                             results_seen, got.status, got.occ, got.last);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got.status !== want.status || got.rec.id_low !== want.rec.id_low
                    || got.rec.id_high !== want.rec.id_high
                    || got.rec.name_low !== want.rec.name_low
                    || got.rec.name_high !== want.rec.name_high
                    || got.occ !== want.occ || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                    begin
                        $display("mismatch at result %0d", results_seen);
                        $display("  expected: status %0d id %h_%h name %h_%h occ %0d last %0b",
                                 want.status, want.rec.id_high, want.rec.id_low,
                                 want.rec.name_high, want.rec.name_low, want.occ, want.last);
                        $display("  actual:   status %0d id %h_%h name %h_%h occ %0d last %0b",
                                 got.status, got.rec.id_high, got.rec.id_low,
                                 got.rec.name_high, got.rec.name_low, got.occ, got.last);
                    end
                end
            end
        end
    end

    // Stimulus build, reset and end of run
    initial
    begin : stimulus
        brd_pkg::rec_t ones;
        brd_pkg::rec_t short_rec;
        int unsigned   ops;
        int unsigned   gen_held;
        int unsigned   roll;
        bit            filling;
        logic [2:0]    fn;

        ones = '1;
        short_rec.id_low    = 64'h0031_3030_3030_3053;   // short ASCII ID
        short_rec.id_high   = 8'h00;
        short_rec.name_low  = 64'h0000_0000_6E61_6E41;   // short ASCII name
        short_rec.name_high = 8'h00;

        // Directed: operations on the empty deque, fill with extreme and
        // short records through both ends (head wraps below slot 0), insert
        // when full at both ends, full display, unused codes, then deletes from both ends.
        push_cmd(brd_pkg::FN_DISPLAY, '0);
        push_cmd(brd_pkg::FN_DEL_FRONT, '0);
        push_cmd(brd_pkg::FN_DEL_REAR, '0);
        push_cmd(brd_pkg::FN_INS_REAR, '0);
        push_cmd(brd_pkg::FN_INS_FRONT, ones);
        push_cmd(brd_pkg::FN_INS_FRONT, short_rec);
        push_cmd(brd_pkg::FN_DISPLAY, '0);
        push_cmd(brd_pkg::FN_INS_REAR, rand_rec());
        push_cmd(brd_pkg::FN_INS_FRONT, rand_rec());
        push_cmd(brd_pkg::FN_INS_REAR, rand_rec());
        push_cmd(brd_pkg::FN_INS_FRONT, rand_rec());
        push_cmd(brd_pkg::FN_INS_REAR, ones);
        push_cmd(brd_pkg::FN_INS_FRONT, rand_rec());
        push_cmd(brd_pkg::FN_INS_REAR, rand_rec());
        push_cmd(brd_pkg::FN_DISPLAY, '0);
        push_cmd(3'd5, ones);
        push_cmd(3'd6, rand_rec());
        push_cmd(3'd7, ones);
        push_cmd(brd_pkg::FN_DEL_FRONT, '0);
        push_cmd(brd_pkg::FN_DEL_REAR, '0);
        push_cmd(brd_pkg::FN_DISPLAY, '0);
        push_cmd(brd_pkg::FN_DEL_FRONT, ones);
        push_cmd(brd_pkg::FN_DEL_REAR, ones);
        push_cmd(brd_pkg::FN_DISPLAY, '0);

        // Random: sweep between empty and full, lingering at either end so
        // full inserts and empty deletes keep occurring.
        gen_held = 4;
        filling  = 1'b0;
        ops      = 0;
        while (ops < RAND_OPS)
        begin
            roll = $urandom_range(0, 99);
            if (gen_held >= DEPTH && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (gen_held == 0 && $urandom_range(0, 2) == 0)
                filling = 1'b1;
            if (roll < 3)
                fn = 3'($urandom_range(5, 7));  // ignored, not counted
            else
            begin
                ops++;
                if (roll < 18)
                    fn = brd_pkg::FN_DISPLAY;
                else if ($urandom_range(0, 99) < (filling ? 70 : 30))
                begin
                    fn = $urandom_range(0, 1) ? brd_pkg::FN_INS_FRONT
                                              : brd_pkg::FN_INS_REAR;
                    if (gen_held < DEPTH)
                        gen_held++;
                end
                else
                begin
                    fn = $urandom_range(0, 1) ? brd_pkg::FN_DEL_FRONT
                                              : brd_pkg::FN_DEL_REAR;
                    if (gen_held > 0)
                        gen_held--;
                end
            end
            push_cmd(fn, rand_rec());
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (deque_cmds.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
        // wait on for any stray output after the last expected result
        repeat (2 * DEPTH + 4) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run
    initial
    begin
        #12_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
src/brd_pkg.sv
src/brd_cell.sv
src/bounded_record_deque.sv
verif/tb_top.sv
